@@ design/stq_pkg.sv @@
// Shared types, codes and helpers for the sorted timer event queue.
`timescale 1ns / 1ps
package stq_pkg;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_KILL   = 2'd1,
        OP_EXISTS = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_SET_OK   = 3'd0,
        ST_SET_FULL = 3'd1,
        ST_KILLED   = 3'd2,
        ST_EXISTS   = 3'd3,
        ST_FIRED    = 3'd4,
        ST_NONE_DUE = 3'd5
    } t_status;

    localparam int unsigned RESULT_LIMIT = 16;
    localparam logic [30:0] DELAY_LIMIT  = 31'h4000_0000;
    localparam logic [29:0] DELAY_SAT    = 30'h3FFF_FFFF;

    // Command handed from the front end to the table sequencer.
    typedef struct packed {
        t_op         op;
        logic [31:0] now_ms;
        logic [31:0] expiry;
        logic [30:0] period;
        logic [15:0] owner_id;
        logic [16:0] owner_limit;
        logic [15:0] callback_tag;
    } t_cmd;

    // Magnitude of a signed 31-bit delay, saturated below the limit.
    function automatic logic [29:0] delay_mag(input logic [30:0] raw);
        logic [30:0] neg;
        begin
            neg = ~raw + 31'd1;
            if (!raw[30]) begin
                delay_mag = raw[29:0];
            end else if ((neg & DELAY_LIMIT) != 31'd0) begin
                delay_mag = DELAY_SAT;
            end else begin
                delay_mag = neg[29:0];
            end
        end
    endfunction

endpackage

@@ design/stq_front.sv @@
// Front end: accepts items, works out expiry and period, queues commands.
`timescale 1ns / 1ps
module stq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_op,
    input  logic [31:0]   i_now_ms,
    input  logic [30:0]   i_delay,
    input  logic [15:0]   i_owner_id,
    input  logic [16:0]   i_owner_limit,
    input  logic [15:0]   i_callback_tag,
    output logic          o_cmd_valid,
    output stq_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    stq_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    stq_pkg::t_cmd w_cmd;
    logic [29:0]   w_mag;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_mag              = stq_pkg::delay_mag(i_delay);
        w_cmd.op           = stq_pkg::t_op'(i_op);
        w_cmd.now_ms       = i_now_ms;
        w_cmd.expiry       = i_now_ms + {2'b00, w_mag};
        // store a periodic delay as the negated saturated magnitude
        w_cmd.period       = i_delay[30] ? (31'd0 - {1'b0, w_mag}) : i_delay;
        w_cmd.owner_id     = i_owner_id;
        w_cmd.owner_limit  = i_owner_limit;
        w_cmd.callback_tag = i_callback_tag;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ design/stq_back.sv @@
// Back end: sorted entry table, operation sequencer and output register.
`timescale 1ns / 1ps
module stq_back #(
    parameter int unsigned MAX_EVENTS = 16,
    parameter int unsigned OWNER_BITS = 16,
    localparam int unsigned IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1,
    localparam int unsigned CW = $clog2(MAX_EVENTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  stq_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_status,
    output logic          o_found,
    output logic [4:0]    o_removed_count,
    output logic [15:0]   o_fired_owner,
    output logic [15:0]   o_fired_tag,
    output logic          o_last,
    output logic [CW-1:0] o_count
);

    typedef enum logic [2:0] {
        S_IDLE, S_SET, S_KILL, S_EXIST, S_TCHK, S_TRE, S_TEMIT
    } t_state;

    typedef enum logic [1:0] {A_NONE, A_INS, A_REM} t_act;

    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_EVENTS);
    localparam logic [4:0]    LAST_K   = 5'(stq_pkg::RESULT_LIMIT - 1);

    logic [31:0]           r_exp [MAX_EVENTS];
    logic [30:0]           r_per [MAX_EVENTS];
    logic [OWNER_BITS-1:0] r_own [MAX_EVENTS];
    logic [15:0]           r_tag [MAX_EVENTS];
    logic [31:0]           n_exp [MAX_EVENTS];
    logic [30:0]           n_per [MAX_EVENTS];
    logic [OWNER_BITS-1:0] n_own [MAX_EVENTS];
    logic [15:0]           n_tag [MAX_EVENTS];

    t_state                r_state;
    stq_pkg::t_cmd         r_cmd;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_rm;
    logic [4:0]            r_k;
    logic [31:0]           r_f_exp;
    logic [30:0]           r_f_per;
    logic [OWNER_BITS-1:0] r_f_own;
    logic [15:0]           r_f_tag;

    logic                  r_ov;
    stq_pkg::t_status      r_ostat;
    logic                  r_ofound;
    logic [4:0]            r_orm;
    logic [15:0]           r_oown;
    logic [15:0]           r_otag;
    logic                  r_olast;

    t_act                  w_act;
    logic [IW-1:0]         w_rem_idx;
    logic [31:0]           w_ins_exp;
    logic [30:0]           w_ins_per;
    logic [OWNER_BITS-1:0] w_ins_own;
    logic [15:0]           w_ins_tag;
    logic [MAX_EVENTS-1:0] w_after;
    logic [31:0]           w_diff;
    logic [31:0]           w_due_d;
    logic                  w_due;
    logic                  w_hit;
    logic                  w_kill_match;
    logic [OWNER_BITS-1:0] w_cmd_own;
    logic [OWNER_BITS-1:0] w_kown;
    logic                  w_ofree;
    logic                  w_more;
    logic                  w_head_per;

    assign w_ofree    = !r_ov || i_ready;
    assign w_cmd_own  = OWNER_BITS'(r_cmd.owner_id);
    assign w_kown     = r_own[r_idx[IW-1:0]];
    assign w_due_d    = r_cmd.now_ms - r_exp[0];
    assign w_due      = (r_cnt != '0) && (w_due_d != 32'd0) && !w_due_d[31];
    assign w_more     = (r_k != LAST_K) && w_due;
    assign w_head_per = r_per[0][30];
    assign w_kill_match = (33'(w_kown) >= 33'(w_cmd_own))
                       && (33'(w_kown) < 33'(r_cmd.owner_limit));

    always_comb begin
        w_hit = 1'b0;
        for (int j = 0; j < MAX_EVENTS; j++) begin
            if ((CW'(j) < r_cnt) && (r_own[j] == w_cmd_own)) begin
                w_hit = 1'b1;
            end
        end
    end

    // Pick the table action for this cycle.
    always_comb begin
        w_act     = A_NONE;
        w_rem_idx = '0;
        unique case (r_state)
            S_SET:   if (w_ofree && (r_cnt != FULL_CNT)) w_act = A_INS;
            S_KILL:  if ((r_idx < r_cnt) && w_kill_match) begin
                         w_act     = A_REM;
                         w_rem_idx = r_idx[IW-1:0];
                     end
            S_TCHK:  if (w_due) w_act = A_REM;
            S_TRE:   w_act = A_INS;
            S_TEMIT: if (w_ofree && w_more) w_act = A_REM;
            default: w_act = A_NONE;
        endcase
    end

    always_comb begin
        if (r_state == S_SET) begin
            w_ins_exp = r_cmd.expiry;
            w_ins_per = r_cmd.period;
            w_ins_own = w_cmd_own;
            w_ins_tag = r_cmd.callback_tag;
        end else begin
            w_ins_exp = r_f_exp;
            w_ins_per = r_f_per;
            w_ins_own = r_f_own;
            w_ins_tag = r_f_tag;
        end
    end

    // Mark slots at or past the insert point: first valid entry that expires later.
    always_comb begin
        for (int j = 0; j < MAX_EVENTS; j++) begin
            w_diff     = w_ins_exp - r_exp[j];
            w_after[j] = (CW'(j) >= r_cnt) || ((CW'(j) < r_cnt) && w_diff[31]);
            if (j > 0) begin
                w_after[j] = w_after[j] || w_after[j-1];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_EVENTS; j++) begin
            n_exp[j] = r_exp[j];
            n_per[j] = r_per[j];
            n_own[j] = r_own[j];
            n_tag[j] = r_tag[j];
            unique case (w_act)
                A_INS: if (w_after[j]) begin
                    if (j == 0 || !w_after[(j > 0) ? j - 1 : 0]) begin
                        n_exp[j] = w_ins_exp;
                        n_per[j] = w_ins_per;
                        n_own[j] = w_ins_own;
                        n_tag[j] = w_ins_tag;
                    end else begin
                        n_exp[j] = r_exp[(j > 0) ? j - 1 : 0];
                        n_per[j] = r_per[(j > 0) ? j - 1 : 0];
                        n_own[j] = r_own[(j > 0) ? j - 1 : 0];
                        n_tag[j] = r_tag[(j > 0) ? j - 1 : 0];
                    end
                end
                A_REM: if ((IW'(j) >= w_rem_idx) && (j + 1 < MAX_EVENTS)) begin
                    n_exp[j] = r_exp[(j + 1 < MAX_EVENTS) ? j + 1 : j];
                    n_per[j] = r_per[(j + 1 < MAX_EVENTS) ? j + 1 : j];
                    n_own[j] = r_own[(j + 1 < MAX_EVENTS) ? j + 1 : j];
                    n_tag[j] = r_tag[(j + 1 < MAX_EVENTS) ? j + 1 : j];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_EVENTS; j++) begin
            r_exp[j] <= n_exp[j];
            r_per[j] <= n_per[j];
            r_own[j] <= n_own[j];
            r_tag[j] <= n_tag[j];
        end
    end

    assign o_cmd_pop = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                    r_idx <= '0;
                    r_rm  <= '0;
                    r_k   <= '0;
                    unique case (i_cmd.op)
                        stq_pkg::OP_SET:    r_state <= S_SET;
                        stq_pkg::OP_KILL:   r_state <= S_KILL;
                        stq_pkg::OP_EXISTS: r_state <= S_EXIST;
                        stq_pkg::OP_TICK:   r_state <= S_TCHK;
                        default:            r_state <= S_IDLE;
                    endcase
                end
                S_SET: if (w_ofree) begin
                    r_ov     <= 1'b1;
                    r_ofound <= 1'b0;
                    r_orm    <= '0;
                    r_oown   <= '0;
                    r_otag   <= '0;
                    r_olast  <= 1'b1;
                    if (r_cnt == FULL_CNT) begin
                        r_ostat <= stq_pkg::ST_SET_FULL;
                    end else begin
                        r_ostat <= stq_pkg::ST_SET_OK;
                        r_cnt   <= r_cnt + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_KILL: begin
                    if (r_idx < r_cnt) begin
                        if (w_kill_match) begin
                            r_cnt <= r_cnt - 1'b1;
                            r_rm  <= r_rm + 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else if (w_ofree) begin
                        r_ov     <= 1'b1;
                        r_ostat  <= stq_pkg::ST_KILLED;
                        r_ofound <= 1'b0;
                        r_orm    <= 5'(r_rm);
                        r_oown   <= '0;
                        r_otag   <= '0;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_EXIST: if (w_ofree) begin
                    r_ov     <= 1'b1;
                    r_ostat  <= stq_pkg::ST_EXISTS;
                    r_ofound <= w_hit;
                    r_orm    <= '0;
                    r_oown   <= '0;
                    r_otag   <= '0;
                    r_olast  <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_TCHK: begin
                    if (w_due) begin
                        // take the head off; requeue it first if periodic
                        r_f_exp <= r_cmd.now_ms + {2'b00, stq_pkg::delay_mag(r_per[0])};
                        r_f_per <= r_per[0];
                        r_f_own <= r_own[0];
                        r_f_tag <= r_tag[0];
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= w_head_per ? S_TRE : S_TEMIT;
                    end else if (w_ofree) begin
                        r_ov     <= 1'b1;
                        r_ostat  <= stq_pkg::ST_NONE_DUE;
                        r_ofound <= 1'b0;
                        r_orm    <= '0;
                        r_oown   <= '0;
                        r_otag   <= '0;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_TRE: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_TEMIT;
                end
                S_TEMIT: if (w_ofree) begin
                    r_ov     <= 1'b1;
                    r_ostat  <= stq_pkg::ST_FIRED;
                    r_ofound <= 1'b0;
                    r_orm    <= '0;
                    r_oown   <= 16'(r_f_own);
                    r_otag   <= r_f_tag;
                    r_olast  <= !w_more;
                    r_k      <= r_k + 5'd1;
                    if (w_more) begin
                        r_f_exp <= r_cmd.now_ms + {2'b00, stq_pkg::delay_mag(r_per[0])};
                        r_f_per <= r_per[0];
                        r_f_own <= r_own[0];
                        r_f_tag <= r_tag[0];
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= w_head_per ? S_TRE : S_TEMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ov;
    assign o_status        = r_ostat;
    assign o_found         = r_ofound;
    assign o_removed_count = r_orm;
    assign o_fired_owner   = r_oown;
    assign o_fired_tag     = r_otag;
    assign o_last          = r_olast;
    assign o_count         = r_cnt;

endmodule

@@ design/sorted_timer_event_queue.sv @@
// Top level of the sorted timer event queue: front end, table sequencer, checks.
//
//  channel | direction | tuser            | tdata (low bit up)                         | tlast
//  s_      | in        | operation [1:0]  | now_ms, delay, owner_id, owner_limit,      | -
//          |           |                  | callback_tag (112 bits)                    |
//  m_      | out       | status [2:0]     | found, removed_count, fired_owner,         | last
//          |           |                  | fired_tag, zero pad (40 bits)              |
//
// Kill walks the table, one table slot checked per cycle; a tick pops each due event
// from the head, and a periodic event is put back into the table by the shared insert
// shifter in its own state before its result is emitted.
// Reset clears the control state and empties the table through its fill count at once.
// A two-deep command queue keeps taking items while the table sequencer waits on m_tready.
`timescale 1ns / 1ps
module sorted_timer_event_queue #(
    parameter int unsigned MAX_EVENTS = 16,
    parameter int unsigned OWNER_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,  // now_ms, delay, owner_id, owner_limit, callback_tag
    input  logic [1:0]   i_s_tuser,  // operation
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [39:0]  o_m_tdata,  // found, removed_count, fired_owner, fired_tag, pad
    output logic [2:0]   o_m_tuser,  // status
    output logic         o_m_tlast
);

    localparam int unsigned CW = $clog2(MAX_EVENTS + 1);

    logic          w_cmd_valid;
    logic          w_cmd_pop;
    stq_pkg::t_cmd w_cmd;
    logic          w_found;
    logic [4:0]    w_rm;
    logic [15:0]   w_own;
    logic [15:0]   w_tag;
    logic [CW-1:0] w_count;

    stq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_op           (i_s_tuser),
        .i_now_ms       (i_s_tdata[31:0]),
        .i_delay        (i_s_tdata[62:32]),
        .i_owner_id     (i_s_tdata[78:63]),
        .i_owner_limit  (i_s_tdata[95:79]),
        .i_callback_tag (i_s_tdata[111:96]),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_pop      (w_cmd_pop)
    );

    stq_back #(
        .MAX_EVENTS (MAX_EVENTS),
        .OWNER_BITS (OWNER_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_cmd_pop       (w_cmd_pop),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_status        (o_m_tuser),
        .o_found         (w_found),
        .o_removed_count (w_rm),
        .o_fired_owner   (w_own),
        .o_fired_tag     (w_tag),
        .o_last          (o_m_tlast),
        .o_count         (w_count)
    );

    assign o_m_tdata = {2'b00, w_tag, w_own, w_rm, w_found};

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(MAX_EVENTS))
        else $error("event count beyond table size");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != stq_pkg::ST_FIRED) |-> o_m_tlast)
        else $error("single-result operation without last");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= stq_pkg::ST_NONE_DUE))
        else $error("undefined status code");
`endif

endmodule

@@ verif/sorted_timer_event_queue_tb.sv @@
// Self-checking testbench for the sorted timer event queue.
`timescale 1ns / 1ps
module sorted_timer_event_queue_tb;

    localparam int TABLE_DEPTH = 16;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        stq_pkg::t_status status;
        logic             found;
        logic [4:0]       removed;
        logic [15:0]      owner;
        logic [15:0]      tag;
        logic             last;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [111:0] i_s_tdata = '0;  // now_ms, delay, owner_id, owner_limit, callback_tag
    logic [1:0]   i_s_tuser = '0;  // operation
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [39:0]  o_m_tdata;       // found, removed_count, fired_owner, fired_tag, pad
    logic [2:0]   o_m_tuser;       // status
    logic         o_m_tlast;

    // Shadow copy of the event table, kept in expiry order.
    logic [31:0] ev_expiry[TABLE_DEPTH];
    logic [30:0] ev_period[TABLE_DEPTH];
    logic [15:0] ev_owner[TABLE_DEPTH];
    logic [15:0] ev_tag[TABLE_DEPTH];
    int          ev_count = 0;

    t_result pending_results[$];
    int      errors = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      fired_seen = 0;
    bit      no_idle = 1'b0;
    bit      hold_off = 1'b0;
    logic [31:0] ms_clock = 32'd1000;

    sorted_timer_event_queue u_top (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [29:0] delay_magnitude(logic [30:0] raw);
        logic [31:0] m;
        m = raw[30] ? (32'h8000_0000 - {1'b0, raw}) : {1'b0, raw};
        if (m >= 32'h4000_0000) m = 32'h3FFF_FFFF;
        return m[29:0];
    endfunction

    task automatic table_insert(logic [31:0] expiry, logic [30:0] period,
                                logic [15:0] owner, logic [15:0] tag);
        int pos;
        logic [31:0] d;
        pos = 0;
        if (ev_count >= TABLE_DEPTH) return;
        while (pos < ev_count) begin
            d = expiry - ev_expiry[pos];
            if (d[31]) break;
            pos++;
        end
        for (int i = ev_count; i > pos; i--) begin
            ev_expiry[i] = ev_expiry[i-1];
            ev_period[i] = ev_period[i-1];
            ev_owner[i]  = ev_owner[i-1];
            ev_tag[i]    = ev_tag[i-1];
        end
        ev_expiry[pos] = expiry;
        ev_period[pos] = period;
        ev_owner[pos]  = owner;
        ev_tag[pos]    = tag;
        ev_count++;
    endtask

    task automatic table_remove(int pos);
        for (int i = pos; i + 1 < ev_count; i++) begin
            ev_expiry[i] = ev_expiry[i+1];
            ev_period[i] = ev_period[i+1];
            ev_owner[i]  = ev_owner[i+1];
            ev_tag[i]    = ev_tag[i+1];
        end
        ev_count--;
    endtask

    task automatic push_result(stq_pkg::t_status st, logic found, logic [4:0] removed,
                               logic [15:0] owner, logic [15:0] tag);
        t_result r;
        r.status  = st;
        r.found   = found;
        r.removed = removed;
        r.owner   = owner;
        r.tag     = tag;
        r.last    = 1'b0;
        pending_results.push_back(r);
    endtask

    // Apply one accepted item to the shadow table and queue its results.
    task automatic predict_queue_op(stq_pkg::t_op op, logic [31:0] now, logic [30:0] raw,
                                    logic [15:0] owner, logic [16:0] lim,
                                    logic [15:0] tag);
        logic [29:0] mag;
        logic [31:0] period32;
        logic [31:0] d;
        logic [15:0] f_owner, f_tag;
        logic [30:0] f_period;
        int          removed;
        int          fired;
        logic        hit;
        int          i;
        case (op)
            stq_pkg::OP_SET: begin
                if (ev_count >= TABLE_DEPTH) begin
                    push_result(stq_pkg::ST_SET_FULL, 1'b0, '0, '0, '0);
                end else begin
                    mag = delay_magnitude(raw);
                    period32 = raw[30] ? (32'h8000_0000 - {2'b0, mag}) : {2'b0, mag};
                    table_insert(now + {2'b0, mag}, period32[30:0], owner, tag);
                    push_result(stq_pkg::ST_SET_OK, 1'b0, '0, '0, '0);
                end
            end
            stq_pkg::OP_KILL: begin
                removed = 0;
                i = 0;
                while (i < ev_count) begin
                    if ({1'b0, ev_owner[i]} >= {1'b0, owner} && {1'b0, ev_owner[i]} < lim) begin
                        table_remove(i);
                        removed++;
                    end else begin
                        i++;
                    end
                end
                push_result(stq_pkg::ST_KILLED, 1'b0, removed[4:0], '0, '0);
            end
            stq_pkg::OP_EXISTS: begin
                hit = 1'b0;
                for (int j = 0; j < ev_count; j++) if (ev_owner[j] == owner) hit = 1'b1;
                push_result(stq_pkg::ST_EXISTS, hit, '0, '0, '0);
            end
            default: begin
                fired = 0;
                while (fired < stq_pkg::RESULT_LIMIT && ev_count > 0) begin
                    d = now - ev_expiry[0];
                    if (d == 0 || d[31]) break;
                    f_owner  = ev_owner[0];
                    f_tag    = ev_tag[0];
                    f_period = ev_period[0];
                    table_remove(0);
                    // Put periodic events back one period after now.
                    if (f_period[30])
                        table_insert(now + {2'b0, delay_magnitude(f_period)}, f_period,
                                     f_owner, f_tag);
                    push_result(stq_pkg::ST_FIRED, 1'b0, '0, f_owner, f_tag);
                    fired++;
                end
                if (fired == 0) push_result(stq_pkg::ST_NONE_DUE, 1'b0, '0, '0, '0);
            end
        endcase
        pending_results[pending_results.size()-1].last = 1'b1;
    endtask

    task automatic send_item(stq_pkg::t_op op, logic [31:0] now, logic [30:0] dly,
                             logic [15:0] owner, logic [16:0] lim, logic [15:0] tag);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {tag, lim, owner, dly, now};
        do @(posedge i_clk); while (!o_s_tready);
        predict_queue_op(op, now, dly, owner, lim, tag);
        items_sent++;
    endtask

    task automatic go_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Receiver: random stall before each result, or a long hold when asked.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                i_m_tready <= 1'b0;
                @(posedge i_clk);
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 18);
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_m_tready <= 1'b1;
                do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready) && !hold_off);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (o_m_tuser == stq_pkg::ST_FIRED) fired_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $realtime, o_m_tuser);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_m_tuser != e.status) begin
                    $display("%0t: status exp %0d got %0d", $realtime, e.status, o_m_tuser);
                    errors++;
                end
                if (o_m_tdata[0] != e.found) begin
                    $display("%0t: found exp %0d got %0d", $realtime, e.found, o_m_tdata[0]);
                    errors++;
                end
                if (o_m_tdata[5:1] != e.removed) begin
                    $display("%0t: removed exp %0d got %0d", $realtime, e.removed,
                             o_m_tdata[5:1]);
                    errors++;
                end
                if (o_m_tdata[21:6] != e.owner) begin
                    $display("%0t: owner exp %h got %h", $realtime, e.owner, o_m_tdata[21:6]);
                    errors++;
                end
                if (o_m_tdata[37:22] != e.tag) begin
                    $display("%0t: tag exp %h got %h", $realtime, e.tag, o_m_tdata[37:22]);
                    errors++;
                end
                if (o_m_tlast != e.last) begin
                    $display("%0t: last exp %0d got %0d", $realtime, e.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic test_basic_ops();
        send_item(stq_pkg::OP_TICK, 32'd100, 31'd0, 16'd0, 17'd0, 16'd0);    // empty tick
        send_item(stq_pkg::OP_SET, 32'd100, 31'd0, 16'd1, 17'd0, 16'hFFFF);   // zero delay
        send_item(stq_pkg::OP_SET, 32'd100, 31'h3FFF_FFFF, 16'hFFFF, 17'd0, 16'h0001);
        send_item(stq_pkg::OP_SET, 32'd100, 31'h7FFF_FFFF, 16'd2, 17'd0, 16'h1234);
        send_item(stq_pkg::OP_SET, 32'd100, 31'h4000_0000, 16'd3, 17'd0, 16'h5678);
        send_item(stq_pkg::OP_SET, 32'd100, 31'd5, 16'd4, 17'd0, 16'hAAAA);
        send_item(stq_pkg::OP_SET, 32'd100, 31'd5, 16'd5, 17'd0, 16'h5555);   // equal time
        send_item(stq_pkg::OP_EXISTS, 32'd100, 31'd0, 16'd4, 17'd0, 16'd0);
        send_item(stq_pkg::OP_EXISTS, 32'd100, 31'd0, 16'd9, 17'd0, 16'd0);
        send_item(stq_pkg::OP_TICK, 32'd100, 31'd0, 16'd0, 17'd0, 16'd0);     // expiry == now
        send_item(stq_pkg::OP_TICK, 32'd101, 31'd0, 16'd0, 17'd0, 16'd0);
        send_item(stq_pkg::OP_TICK, 32'd110, 31'd0, 16'd0, 17'd0, 16'd0);
        send_item(stq_pkg::OP_KILL, 32'd110, 31'd0, 16'd9, 17'd9, 16'd0);     // empty range
        send_item(stq_pkg::OP_KILL, 32'd110, 31'd0, 16'd3, 17'd2, 16'd0);
        send_item(stq_pkg::OP_KILL, 32'd110, 31'd0, 16'd2, 17'd4, 16'd0);
        send_item(stq_pkg::OP_KILL, 32'd110, 31'd0, 16'd0, 17'h1_0000, 16'd0); // everything
        send_item(stq_pkg::OP_SET, 32'hFFFF_FFF0, 31'd32, 16'd7, 17'd0, 16'h0F0F);
        send_item(stq_pkg::OP_TICK, 32'hFFFF_FFFF, 31'd0, 16'd0, 17'd0, 16'd0);
        send_item(stq_pkg::OP_TICK, 32'h0000_0011, 31'd0, 16'd0, 17'd0, 16'd0);
        go_idle();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(stq_pkg::OP_SET, 32'd500, 31'(i % 3), 16'(i), 17'd0,
                      16'(16'hF000 + i));
        send_item(stq_pkg::OP_SET, 32'd500, 31'd1, 16'd99, 17'd0, 16'd0);    // dropped
        send_item(stq_pkg::OP_TICK, 32'd600, 31'd0, 16'd0, 17'd0, 16'd0);    // fires all 16
        go_idle();
    endtask

    task automatic test_many_due();
        // Exactly as many due as the result limit, periodic events counted in.
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(stq_pkg::OP_SET, 32'd700, (i < 4) ? 31'h7FFF_FFFE : 31'd1, 16'(i),
                      17'd0, 16'(i));
        send_item(stq_pkg::OP_TICK, 32'd800, 31'd0, 16'd0, 17'd0, 16'd0);
        send_item(stq_pkg::OP_TICK, 32'd900, 31'd0, 16'd0, 17'd0, 16'd0);
        send_item(stq_pkg::OP_KILL, 32'd900, 31'd0, 16'd0, 17'h1_FFFF, 16'd0);
        go_idle();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        no_idle = 1'b1;
        for (int i = 0; i < 10; i++)
            send_item(stq_pkg::OP_EXISTS, 32'd0, 31'd0, 16'(i), 17'd0, 16'd0);
        no_idle = 1'b0;
        go_idle();
    endtask

    task automatic test_random_traffic();
        int     pick;
        logic [30:0] dly;
        logic [15:0] owner;
        logic [16:0] lim;
        logic [31:0] now;
        for (int n = 0; n < 35; n++) begin
            no_idle = (n >= 10 && n < 20);
            pick = $urandom_range(0, 99);
            now  = ms_clock;
            owner = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
            if ($urandom_range(0, 19) == 0) now = $urandom;
            if (pick < 45) begin
                case ($urandom_range(0, 3))
                    0: dly = 31'($urandom);
                    1: dly = -31'($urandom_range(1, 40));
                    default: dly = 31'($urandom_range(0, 40));
                endcase
                send_item(stq_pkg::OP_SET, now, dly, owner, 17'd0, 16'($urandom));
            end else if (pick < 75) begin
                ms_clock = ms_clock + $urandom_range(0, 30);
                send_item(stq_pkg::OP_TICK, ms_clock, 31'($urandom), 16'($urandom),
                          17'($urandom), 16'($urandom));
            end else if (pick < 88) begin
                lim = ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                                  : 17'(owner) + 17'($urandom_range(0, 4));
                send_item(stq_pkg::OP_KILL, now, 31'($urandom), owner, lim, 16'($urandom));
            end else begin
                send_item(stq_pkg::OP_EXISTS, now, 31'($urandom), owner, 17'($urandom),
                          16'($urandom));
            end
        end
        no_idle = 1'b0;
        go_idle();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_table_full();
        test_many_due();
        test_backpressure();
        test_random_traffic();
        $display("Covered set, kill, exists and tick with wraparound, full table and stalls.");
        $display("Sent %0d items, checked %0d results (%0d fired).", items_sent,
                 results_seen, fired_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
